/* sv/vdu_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vdu_pkg
// Shared widths, metric codes and controller/datapath interface types for
// the vector distance unit.
// ----------------------------------------------------------------------------
package vdu_pkg;

	localparam int ELEM_W     = 16;
	localparam int DIFF_W     = ELEM_W;
	localparam int SQ_W       = 2 * DIFF_W;
	localparam int ACC_W      = 43;
	localparam int OUT_W      = 26;
	localparam int METRIC_W   = 2;
	localparam int ROOT_STEPS = (ACC_W + 1) / 2;
	localparam int ROOT_W     = ROOT_STEPS;
	localparam int RAD_W      = 2 * ROOT_STEPS;
	localparam int REM_W      = ROOT_W + 3;
	localparam int CNT_W      = $clog2(ROOT_STEPS);

	localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
	localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

	localparam logic [METRIC_W-1:0] METRIC_MANHATTAN = 2'd0;
	localparam logic [METRIC_W-1:0] METRIC_EUCLID    = 2'd1;
	localparam logic [METRIC_W-1:0] METRIC_CHEBYSHEV = 2'd2;
	localparam logic [METRIC_W-1:0] METRIC_RESET     = METRIC_EUCLID;

	// Controller to datapath commands
	typedef struct packed {
		logic load_in;
		logic do_diff;
		logic do_sqr;
		logic do_acc;
		logic root_init;
		logic root_step;
		logic load_out;
	} vdu_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic last;
		logic euclid;
	} vdu_sts_t;

endpackage
`default_nettype wire

/* sv/vdu_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vdu_ctrl
// Sequencer for the vector distance unit: steps each pair through difference,
// square and accumulate, runs the root if Euclidean and hands off the result.
// ----------------------------------------------------------------------------
module vdu_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire vdu_pkg::vdu_sts_t sts,
	output vdu_pkg::vdu_cmd_t      cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIFF,
		ST_SQR,
		ST_ACC,
		ST_ROOT_LD,
		ST_ROOT,
		ST_FIN
	} state_t;

	state_t                     state_q;
	logic                       out_valid_q;
	logic [vdu_pkg::CNT_W-1:0]  root_cnt_q;
	logic                       out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE:    cmd.load_in   = in_valid;
			ST_DIFF:    cmd.do_diff   = 1'b1;
			ST_SQR:     cmd.do_sqr    = 1'b1;
			ST_ACC:     cmd.do_acc    = 1'b1;
			ST_ROOT_LD: cmd.root_init = 1'b1;
			ST_ROOT:    cmd.root_step = 1'b1;
			ST_FIN:     cmd.load_out  = out_free;
			default:    cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			root_cnt_q  <= '0;
		end else begin
			// raise on a fresh load, drop once taken
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_DIFF;
					end
				end
				ST_DIFF: state_q <= ST_SQR;
				ST_SQR:  state_q <= ST_ACC;
				ST_ACC: begin
					if (!sts.last) begin
						state_q <= ST_IDLE;
					end else if (sts.euclid) begin
						state_q <= ST_ROOT_LD;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_ROOT_LD: begin
					root_cnt_q <= '0;
					state_q    <= ST_ROOT;
				end
				ST_ROOT: begin
					root_cnt_q <= root_cnt_q + 1'b1;
					if (root_cnt_q == vdu_pkg::CNT_W'(vdu_pkg::ROOT_STEPS - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					// hold until the output register is free
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

/* sv/vdu_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vdu_datapath
// Metric register, difference/square stages, saturating accumulator,
// digit-by-digit square root and the output register.
// ----------------------------------------------------------------------------
module vdu_datapath (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [vdu_pkg::METRIC_W-1:0]        cfg_wdata,
	input  wire logic signed [vdu_pkg::ELEM_W-1:0]   x_element,
	input  wire logic signed [vdu_pkg::ELEM_W-1:0]   y_element,
	input  wire logic                                last_element,
	input  wire vdu_pkg::vdu_cmd_t                   cmd,
	output vdu_pkg::vdu_sts_t                        sts,
	output logic [vdu_pkg::OUT_W-1:0]                distance
);

	logic [vdu_pkg::METRIC_W-1:0]      metric_q;
	logic [vdu_pkg::ACC_W-1:0]         acc_q;

	logic signed [vdu_pkg::ELEM_W-1:0] x_s1;
	logic signed [vdu_pkg::ELEM_W-1:0] y_s1;
	logic                              last_s1;
	logic [vdu_pkg::DIFF_W-1:0]        ad_s2;
	logic [vdu_pkg::SQ_W-1:0]          sq_s3;

	logic [vdu_pkg::RAD_W-1:0]         rad_q;
	logic [vdu_pkg::REM_W-1:0]         rem_q;
	logic [vdu_pkg::ROOT_W-1:0]        root_q;
	logic [vdu_pkg::OUT_W-1:0]         distance_q;

	logic                              euclid;
	logic signed [vdu_pkg::ELEM_W:0]   diff;
	logic [vdu_pkg::ELEM_W:0]          diff_mag;
	logic [vdu_pkg::SQ_W-1:0]          sq_val;
	logic [vdu_pkg::ACC_W:0]           sum;
	logic [vdu_pkg::ACC_W-1:0]         sq_ext;
	logic [vdu_pkg::ACC_W-1:0]         acc_nxt;
	logic [vdu_pkg::REM_W-1:0]         rem_sh;
	logic [vdu_pkg::REM_W-1:0]         trial;
	logic [vdu_pkg::OUT_W-1:0]         acc_sat;

	assign euclid = (metric_q == vdu_pkg::METRIC_EUCLID);

	assign diff     = {x_s1[vdu_pkg::ELEM_W-1], x_s1} - {y_s1[vdu_pkg::ELEM_W-1], y_s1};
	assign diff_mag = diff[vdu_pkg::ELEM_W] ? -diff : diff;

	always_comb begin
		if (euclid) begin
			sq_val = ad_s2 * ad_s2;
		end else begin
			sq_val = vdu_pkg::SQ_W'(ad_s2);
		end
	end

	assign sum    = {1'b0, acc_q} + (vdu_pkg::ACC_W + 1)'(sq_s3);
	assign sq_ext = vdu_pkg::ACC_W'(sq_s3);

	always_comb begin
		case (metric_q)
			vdu_pkg::METRIC_MANHATTAN,
			vdu_pkg::METRIC_EUCLID: begin
				acc_nxt = sum[vdu_pkg::ACC_W] ? vdu_pkg::ACC_MAX : sum[vdu_pkg::ACC_W-1:0];
			end
			default: begin
				// maximum; the unused code behaves the same
				acc_nxt = (sq_ext > acc_q) ? sq_ext : acc_q;
			end
		endcase
	end

	// one result bit per step: bring down two radicand bits, try 4r+1
	assign rem_sh = {rem_q[vdu_pkg::REM_W-3:0], rad_q[vdu_pkg::RAD_W-1 -: 2]};
	assign trial  = vdu_pkg::REM_W'({root_q, 2'b01});

	assign acc_sat = (|acc_q[vdu_pkg::ACC_W-1:vdu_pkg::OUT_W]) ? vdu_pkg::OUT_MAX
	                                                          : acc_q[vdu_pkg::OUT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			metric_q <= vdu_pkg::METRIC_RESET;
			acc_q    <= '0;
		end else begin
			if (cfg_we) begin
				metric_q <= cfg_wdata;
			end
			if (cmd.do_acc) begin
				acc_q <= acc_nxt;
			end else if (cmd.load_out) begin
				acc_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			x_s1    <= x_element;
			y_s1    <= y_element;
			last_s1 <= last_element;
		end
		if (cmd.do_diff) begin
			ad_s2 <= diff_mag[vdu_pkg::DIFF_W-1:0];
		end
		if (cmd.do_sqr) begin
			sq_s3 <= sq_val;
		end
		if (cmd.root_init) begin
			rad_q  <= vdu_pkg::RAD_W'(acc_q);
			rem_q  <= '0;
			root_q <= '0;
		end else if (cmd.root_step) begin
			rad_q <= rad_q << 2;
			if (rem_sh >= trial) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[vdu_pkg::ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[vdu_pkg::ROOT_W-2:0], 1'b0};
			end
		end
		if (cmd.load_out) begin
			distance_q <= euclid ? vdu_pkg::OUT_W'(root_q) : acc_sat;
		end
	end

	assign sts.last   = last_s1;
	assign sts.euclid = euclid;
	assign distance   = distance_q;

endmodule
`default_nettype wire

/* sv/vector_distance_unit_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vector_distance_unit_core
// Streaming L1 / L2 / L-infinity distance between two signed vectors.
// ----------------------------------------------------------------------------
// Element pairs arrive one per input request (x_element, y_element, with
// last_element marking the final pair) and fold into a 43-bit saturating
// accumulator under the metric in cfg_wdata (0 Manhattan sum of |x-y|,
// 1 Euclidean floor(sqrt(sum of squares)), 2 or 3 Chebyshev maximum; reset
// selects Euclidean). Each pair runs through capture, difference, square and
// accumulate, one after the other under the controller, and the next pair is
// accepted only once the current one is through. On the last pair the distance
// is written to the output register, saturated to 26 bits, and the accumulator
// clears; for Euclidean the root unit is first loaded and a digit-by-digit root
// that produces one result bit per cycle runs before the result is written.
// A waiting result does not block new pairs; only the next last pair waits for
// the output register to empty, for as long as the result stays untaken.
// Write the metric only while the unit is idle.
// ----------------------------------------------------------------------------
module vector_distance_unit_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [vdu_pkg::METRIC_W-1:0]        cfg_wdata,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic signed [vdu_pkg::ELEM_W-1:0]   x_element,
	input  wire logic signed [vdu_pkg::ELEM_W-1:0]   y_element,
	input  wire logic                                last_element,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [vdu_pkg::OUT_W-1:0]                distance
);

	vdu_pkg::vdu_cmd_t cmd;
	vdu_pkg::vdu_sts_t sts;

	// sequencing and output handshake
	vdu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// arithmetic, accumulator, root and result register
	vdu_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.x_element    (x_element),
		.y_element    (y_element),
		.last_element (last_element),
		.cmd          (cmd),
		.sts          (sts),
		.distance     (distance)
	);

	// one request in flight: after acceptance the port closes
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while a request is still in work");

	// never overwrite a result that has not been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid || out_ready))
		else $error("result register loaded while full");

	// a new result is always flagged the cycle after it is loaded
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid)
		else $error("loaded result not presented");

	// the root unit only runs while the input port is closed
	a_root_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.root_step || cmd.root_init) |-> !in_ready)
		else $error("root running while input port open");

endmodule
`default_nettype wire
